// File: design/l4swem_pkg.sv
// Shared types, constants and helper functions of the L4S WRED ECN marker.
`timescale 1ns / 1ps
`default_nettype none

package l4swem_pkg;

  localparam int NUM_QUEUES     = 64;
  localparam int NUM_PROFILES   = 4;
  localparam int NUM_PRIORITIES = 8;

  localparam int PROF_DEPTH = NUM_PROFILES * NUM_PRIORITIES;
  localparam int QAW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PAW = (PROF_DEPTH > 1) ? $clog2(PROF_DEPTH) : 1;

  localparam int UTIL_W  = 7;
  localparam int PROB_W  = 11;
  localparam int SLOPE_W = 8;
  localparam int PROD_W  = UTIL_W + SLOPE_W;

  localparam logic [PROB_W-1:0] PROB_MAX_Q4   = 11'd2032;
  localparam logic [7:0]        RAND_MOD      = 8'd127;
  localparam int                Q4_SHIFT      = 4;
  localparam logic [7:0]        ECN_KEEP_MASK = 8'hfc;
  localparam logic [1:0]        ECN_CE        = 2'd3;

  localparam logic [8:0] QIDX_LIMIT = 9'(NUM_QUEUES);
  localparam logic [4:0] PROF_LIMIT = 5'(NUM_PROFILES);
  localparam logic [4:0] PRI_LIMIT  = 5'(NUM_PRIORITIES);
  localparam logic [8:0] PRI_COUNT  = 9'(NUM_PRIORITIES);

  typedef enum logic [1:0] {
    REQ_PACKET   = 2'd0,
    REQ_COUPLING = 2'd1,
    REQ_PROFILE  = 2'd2,
    REQ_RSVD     = 2'd3
  } req_type_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [6:0]  lq_util;
    logic [5:0]  queue_sel;
    logic [1:0]  profile_index;
    logic [2:0]  priority_req;
    logic [1:0]  ecn_in;
    logic [31:0] random_word;
    logic [10:0] coupling_q4;
    logic [6:0]  ramp_start;
    logic [7:0]  slope_q4;
    logic [6:0]  drop_threshold;
  } in_req_t;

  typedef struct packed {
    logic        accepted;
    logic        marked;
    logic [1:0]  ecn_out;
    logic [10:0] mark_prob_q4;
  } out_res_t;

  typedef struct packed {
    logic [UTIL_W-1:0]  drop;
    logic [SLOPE_W-1:0] slope;
    logic [UTIL_W-1:0]  start;
  } prof_entry_t;

  typedef struct packed {
    logic [UTIL_W-1:0] util;
    logic [1:0]        ecn;
    logic [6:0]        rmod;
  } pkt_ctx_t;

  // Fold 7-bit digits: 2^7 is 1 modulo 127.
  function automatic logic [6:0] rand_mod127(input logic [31:0] x);
    logic [9:0] s;
    logic [7:0] t;
    s = 10'(x[6:0]) + 10'(x[13:7]) + 10'(x[20:14]) + 10'(x[27:21]) + 10'(x[31:28]);
    t = 8'(s[6:0]) + 8'(s[9:7]);
    if (t >= RAND_MOD) begin
      t = t - RAND_MOD;
    end
    return t[6:0];
  endfunction

endpackage

`default_nettype wire

// File: design/l4s_wred_ecn_marker.sv
// L4S WRED ECN marker: top level with request intake, table memories and decision stage.
//
// One request channel (in_valid_i / in_stall_o / in_req_i) carries three kinds of
// request: packet, coupling update and profile write. One result channel
// (out_valid_o / out_stall_i / out_res_o) returns one result per packet; updates
// and profile writes produce none and take effect on the cycle they are accepted.
// A packet reads its coupling entry and profile entry from the memories at the
// accept edge; the decision runs in the next cycle and lands in the output
// register once that register is free, and out_valid_o then rises.
// Throughput is one request per cycle while the receiver does not stall; the two
// memory reads and one multiply per packet are spread over the two stages.
// Reset clears the pipeline and the coupling valid bits, so every coupling
// entry reads as zero until written; profile entries must be written before
// a packet uses them. While the receiver stalls with a result waiting, one more
// packet is held in the decision stage, after which in_stall_o rises.
`timescale 1ns / 1ps
`default_nettype none

module l4s_wred_ecn_marker (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire l4swem_pkg::in_req_t   in_req_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output l4swem_pkg::out_res_t       out_res_o
);

  logic accept, is_pkt, is_coup, is_prof;
  logic q_ok, prof_ok, pkt_acc, load;
  logic s1_valid_q;
  logic q_ok_q, prof_ok_q;
  l4swem_pkg::pkt_ctx_t ctx_d, ctx_q;
  l4swem_pkg::prof_entry_t prof_wr, prof_rd, prof_eff;
  logic [l4swem_pkg::PROB_W-1:0] coup_sat, coup_rd, coup_eff;
  logic [7:0] qidx_ext;
  logic [8:0] slot_ext;
  logic [l4swem_pkg::QAW-1:0] qaddr;
  logic [l4swem_pkg::PAW-1:0] paddr;

  assign in_stall_o = s1_valid_q && !load;
  assign accept     = in_valid_i && !in_stall_o;

  assign is_pkt  = in_req_i.req_type == l4swem_pkg::REQ_PACKET;
  assign is_coup = in_req_i.req_type == l4swem_pkg::REQ_COUPLING;
  assign is_prof = in_req_i.req_type == l4swem_pkg::REQ_PROFILE;

  assign qidx_ext = {2'b0, in_req_i.queue_sel};
  assign qaddr    = qidx_ext[l4swem_pkg::QAW-1:0];
  assign q_ok     = {1'b0, qidx_ext} < l4swem_pkg::QIDX_LIMIT;

  assign slot_ext = 9'(in_req_i.profile_index) * l4swem_pkg::PRI_COUNT
                  + 9'(in_req_i.priority_req);
  assign paddr    = slot_ext[l4swem_pkg::PAW-1:0];
  assign prof_ok  = ({3'b0, in_req_i.profile_index} < l4swem_pkg::PROF_LIMIT) &&
                    ({2'b0, in_req_i.priority_req} < l4swem_pkg::PRI_LIMIT);

  assign pkt_acc = accept && is_pkt;

  assign coup_sat = (in_req_i.coupling_q4 > l4swem_pkg::PROB_MAX_Q4) ?
                    l4swem_pkg::PROB_MAX_Q4 : in_req_i.coupling_q4;

  assign prof_wr.start = in_req_i.ramp_start;
  assign prof_wr.slope = in_req_i.slope_q4;
  assign prof_wr.drop  = in_req_i.drop_threshold;

  assign ctx_d.util = in_req_i.lq_util;
  assign ctx_d.ecn  = in_req_i.ecn_in;
  assign ctx_d.rmod = l4swem_pkg::rand_mod127(in_req_i.random_word);

  l4swem_coup_ram u_coup_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && is_coup && q_ok),
    .wr_addr_i (qaddr),
    .wr_data_i (coup_sat),
    .rd_en_i   (pkt_acc),
    .rd_addr_i (qaddr),
    .rd_data_o (coup_rd)
  );

  l4swem_prof_ram u_prof_ram (
    .clk_i     (clk_i),
    .wr_en_i   (accept && is_prof && prof_ok),
    .wr_addr_i (paddr),
    .wr_data_i (prof_wr),
    .rd_en_i   (pkt_acc),
    .rd_addr_i (paddr),
    .rd_data_o (prof_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= pkt_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pkt_acc) begin
      ctx_q     <= ctx_d;
      q_ok_q    <= q_ok;
      prof_ok_q <= prof_ok;
    end
  end

  assign coup_eff = q_ok_q ? coup_rd : '0;
  assign prof_eff = prof_ok_q ? prof_rd : '0;

  l4swem_decide u_decide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s1_valid_i  (s1_valid_q),
    .ctx_i       (ctx_q),
    .prof_i      (prof_eff),
    .coup_i      (coup_eff),
    .load_o      (load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_o && out_stall_i))
    else $error("request stalled with room in the pipeline");

  a_pkt_reaches_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pkt_acc |=> s1_valid_q)
    else $error("accepted packet missing from decision stage");

  a_nonpkt_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_pkt) |=> !s1_valid_q)
    else $error("non-packet request produced a result");

endmodule

`default_nettype wire

// File: design/l4swem_coup_ram.sv
// Coupling probability memory with per-entry valid bits cleared at reset.
`timescale 1ns / 1ps
`default_nettype none

module l4swem_coup_ram (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            wr_en_i,
  input  wire logic [l4swem_pkg::QAW-1:0]      wr_addr_i,
  input  wire logic [l4swem_pkg::PROB_W-1:0]   wr_data_i,
  input  wire logic                            rd_en_i,
  input  wire logic [l4swem_pkg::QAW-1:0]      rd_addr_i,
  output logic      [l4swem_pkg::PROB_W-1:0]   rd_data_o
);

  logic [l4swem_pkg::PROB_W-1:0] mem_q [l4swem_pkg::NUM_QUEUES];
  logic [l4swem_pkg::NUM_QUEUES-1:0] vld_q;
  logic [l4swem_pkg::PROB_W-1:0] rd_q;
  logic rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_q : '0;

endmodule

`default_nettype wire

// File: design/l4swem_prof_ram.sv
// Profile memory holding start point, slope and drop point per slot.
`timescale 1ns / 1ps
`default_nettype none

module l4swem_prof_ram (
  input  wire logic                         clk_i,
  input  wire logic                         wr_en_i,
  input  wire logic [l4swem_pkg::PAW-1:0]   wr_addr_i,
  input  wire l4swem_pkg::prof_entry_t      wr_data_i,
  input  wire logic                         rd_en_i,
  input  wire logic [l4swem_pkg::PAW-1:0]   rd_addr_i,
  output l4swem_pkg::prof_entry_t           rd_data_o
);

  l4swem_pkg::prof_entry_t mem_q [l4swem_pkg::PROF_DEPTH];
  l4swem_pkg::prof_entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

`default_nettype wire

// File: design/l4swem_decide.sv
// Ramp probability, coupling max, drop and mark decision, and output register.
`timescale 1ns / 1ps
`default_nettype none

module l4swem_decide (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           s1_valid_i,
  input  wire l4swem_pkg::pkt_ctx_t           ctx_i,
  input  wire l4swem_pkg::prof_entry_t        prof_i,
  input  wire logic [l4swem_pkg::PROB_W-1:0]  coup_i,
  output logic                                load_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output l4swem_pkg::out_res_t                out_res_o
);

  logic out_valid_q;
  l4swem_pkg::out_res_t res_q, res_d;
  logic [l4swem_pkg::UTIL_W-1:0] diff;
  logic [l4swem_pkg::PROD_W-1:0] prod;
  logic [l4swem_pkg::PROB_W-1:0] ramp, prob, rand_q4;
  logic [7:0] ecn_wide;
  logic out_free;

  always_comb begin
    diff = (ctx_i.util > prof_i.start) ? (ctx_i.util - prof_i.start) : '0;
    prod = l4swem_pkg::PROD_W'(diff) * l4swem_pkg::PROD_W'(prof_i.slope);
    ramp = (prod > l4swem_pkg::PROD_W'(l4swem_pkg::PROB_MAX_Q4)) ?
           l4swem_pkg::PROB_MAX_Q4 : prod[l4swem_pkg::PROB_W-1:0];
    prob = (coup_i > ramp) ? coup_i : ramp;
    rand_q4 = {ctx_i.rmod, {l4swem_pkg::Q4_SHIFT{1'b0}}};
    ecn_wide = ({6'b0, ctx_i.ecn} & l4swem_pkg::ECN_KEEP_MASK) | {6'b0, l4swem_pkg::ECN_CE};
    res_d.accepted = ctx_i.util < prof_i.drop;
    res_d.marked = res_d.accepted && (rand_q4 < prob);
    res_d.ecn_out = res_d.marked ? ecn_wide[1:0] : ctx_i.ecn;
    res_d.mark_prob_q4 = prob;
  end

  assign out_free = !out_valid_q || !out_stall_i;
  assign load_o   = s1_valid_i && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  a_mark_needs_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!res_q.marked || res_q.accepted))
    else $error("marked result not accepted");

  a_prob_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.mark_prob_q4 <= l4swem_pkg::PROB_MAX_Q4))
    else $error("probability above maximum");

  a_mark_ce: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && res_q.marked) |-> (res_q.ecn_out == l4swem_pkg::ECN_CE))
    else $error("marked result without CE");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !load_o)
    else $error("output register loaded while held");

  a_no_lost_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_i && !load_o) |=> out_valid_q)
    else $error("pending packet with empty output");

endmodule

`default_nettype wire
